>>> src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: shared package
// Widths, payload types and the task record passed from front to back.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int DIFW  = CW + 1;        // vertex and offset differences
    localparam int DOTW  = 2 * DIFW + 2;  // dot products
    localparam int AREAW = 2 * DOTW + 1;  // signed areas
    localparam int QW    = AREAW + 2;     // quotient numerators and divisors
    localparam int RW    = QW + 1;        // divider remainder
    localparam int WB    = 16;            // weight fraction bits
    localparam int WW    = WB + 1;        // weight width
    localparam int PW    = WW + 1 + DIFW; // weight times edge
    localparam int TW    = PW + 2;        // interpolation sum

    localparam logic [WW-1:0] W_ONE = {1'b1, {WB{1'b0}}};

    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] vert_a_x;
        logic signed [CW-1:0] vert_a_y;
        logic signed [CW-1:0] vert_a_z;
        logic signed [CW-1:0] vert_b_x;
        logic signed [CW-1:0] vert_b_y;
        logic signed [CW-1:0] vert_b_z;
        logic signed [CW-1:0] vert_c_x;
        logic signed [CW-1:0] vert_c_y;
        logic signed [CW-1:0] vert_c_z;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] near_x;
        logic signed [CW-1:0] near_y;
        logic signed [CW-1:0] near_z;
        logic [WW-1:0]        weight_a;
        logic [WW-1:0]        weight_b;
        logic [WW-1:0]        weight_c;
        logic                 degenerate;
    } t_out;

    // Vertex a and the edges ab and ac, as needed for the final interpolation.
    typedef struct packed {
        logic [2:0][CW-1:0]   a;
        logic [2:0][DIFW-1:0] ab;
        logic [2:0][DIFW-1:0] ac;
    } t_geo;

    // One classified item: two quotient lanes (weights of b and c), flags and geometry.
    typedef struct packed {
        logic signed [QW-1:0] nb;
        logic signed [QW-1:0] db;
        logic signed [QW-1:0] nc;
        logic signed [QW-1:0] dc;
        logic                 ebc;
        logic                 face;
        logic                 degen;
        t_geo                 geo;
    } t_task;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dvs;
        logic [WB-1:0] q;
        logic          sat;
        logic          zero;
    } t_lane;

endpackage

>>> src/cpt_front.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: front end
// Differences, dot products, signed areas and region classification.
// ----------------------------------------------------------------------------
module cpt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cpt_pkg::t_in   i_item,
    input  logic           i_q_full,
    output logic           o_wr,
    output cpt_pkg::t_task o_task
);

    localparam int MW    = 2 * cpt_pkg::DIFW;
    localparam int SPLIT = cpt_pkg::DOTW / 2;
    localparam int HW    = cpt_pkg::DOTW - SPLIT;
    localparam int PRW   = 2 * cpt_pkg::DOTW;
    localparam int EW    = cpt_pkg::DOTW + 1;
    localparam int NST   = 7;

    // Area product operands: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6,
    // va = d3*d6 - d5*d4 (d1 at index 0).
    localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

    typedef enum logic [2:0] {
        RG_VA, RG_VB, RG_EAB, RG_VC, RG_EAC, RG_EBC, RG_FACE, RG_DEGEN
    } t_region;

    logic                         en;
    logic [NST-1:0]               r_vld;
    cpt_pkg::t_geo                r_geo [NST-1];
    logic signed [cpt_pkg::CW-1:0]   w_p [3], w_a [3], w_b [3], w_c [3];
    logic signed [cpt_pkg::DIFW-1:0] r_ab [3], r_ac [3], r_ap [3], r_bp [3], r_cp [3];
    logic signed [cpt_pkg::DIFW-1:0] w_e [2][3], w_o [3][3];
    logic signed [MW-1:0]            r_mp [6][3];
    logic signed [cpt_pkg::DOTW-1:0] r_d3 [6], r_d4 [6], r_d5 [6], r_d6 [6];
    logic signed [2*HW-1:0]          r_hh [6];
    logic signed [HW+SPLIT:0]        r_hl [6], r_lh [6];
    logic [2*SPLIT-1:0]              r_ll [6];
    logic signed [PRW-1:0]           r_pr [6];
    logic signed [cpt_pkg::AREAW-1:0] r_va, r_vb, r_vc;
    logic signed [EW-1:0]            d43, d56;
    logic signed [cpt_pkg::QW-1:0]   den;
    t_region                         w_rg;
    cpt_pkg::t_task                  w_task, r_task;

    assign en   = !i_q_full;
    assign o_wr = en && r_vld[NST-1];
    assign o_task = r_task;

    assign w_p[0] = i_item.point_x;  assign w_p[1] = i_item.point_y;
    assign w_p[2] = i_item.point_z;
    assign w_a[0] = i_item.vert_a_x; assign w_a[1] = i_item.vert_a_y;
    assign w_a[2] = i_item.vert_a_z;
    assign w_b[0] = i_item.vert_b_x; assign w_b[1] = i_item.vert_b_y;
    assign w_b[2] = i_item.vert_b_z;
    assign w_c[0] = i_item.vert_c_x; assign w_c[1] = i_item.vert_c_y;
    assign w_c[2] = i_item.vert_c_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_e[0][k] = r_ab[k];
            w_e[1][k] = r_ac[k];
            w_o[0][k] = r_ap[k];
            w_o[1][k] = r_bp[k];
            w_o[2][k] = r_cp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1: differences.
            for (int k = 0; k < 3; k++) begin
                r_geo[0].a[k]  <= w_a[k];
                r_geo[0].ab[k] <= cpt_pkg::DIFW'(w_b[k]) - cpt_pkg::DIFW'(w_a[k]);
                r_geo[0].ac[k] <= cpt_pkg::DIFW'(w_c[k]) - cpt_pkg::DIFW'(w_a[k]);
                r_ab[k] <= cpt_pkg::DIFW'(w_b[k]) - cpt_pkg::DIFW'(w_a[k]);
                r_ac[k] <= cpt_pkg::DIFW'(w_c[k]) - cpt_pkg::DIFW'(w_a[k]);
                r_ap[k] <= cpt_pkg::DIFW'(w_p[k]) - cpt_pkg::DIFW'(w_a[k]);
                r_bp[k] <= cpt_pkg::DIFW'(w_p[k]) - cpt_pkg::DIFW'(w_b[k]);
                r_cp[k] <= cpt_pkg::DIFW'(w_p[k]) - cpt_pkg::DIFW'(w_c[k]);
            end
            for (int s = 1; s < NST-1; s++) begin
                r_geo[s] <= r_geo[s-1];
            end
            // Stage 2: the eighteen component products.
            for (int oi = 0; oi < 3; oi++) begin
                for (int ei = 0; ei < 2; ei++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mp[2*oi+ei][k] <= w_e[ei][k] * w_o[oi][k];
                    end
                end
            end
            // Stage 3: dot products d1..d6.
            for (int j = 0; j < 6; j++) begin
                r_d3[j] <= cpt_pkg::DOTW'(r_mp[j][0]) + cpt_pkg::DOTW'(r_mp[j][1])
                         + cpt_pkg::DOTW'(r_mp[j][2]);
            end
            // Stage 4: area products split into halves.
            for (int i = 0; i < 6; i++) begin
                r_hh[i] <= $signed(r_d3[PA[i]][cpt_pkg::DOTW-1:SPLIT])
                         * $signed(r_d3[PB[i]][cpt_pkg::DOTW-1:SPLIT]);
                r_hl[i] <= $signed(r_d3[PA[i]][cpt_pkg::DOTW-1:SPLIT])
                         * $signed({1'b0, r_d3[PB[i]][SPLIT-1:0]});
                r_lh[i] <= $signed({1'b0, r_d3[PA[i]][SPLIT-1:0]})
                         * $signed(r_d3[PB[i]][cpt_pkg::DOTW-1:SPLIT]);
                r_ll[i] <= r_d3[PA[i]][SPLIT-1:0] * r_d3[PB[i]][SPLIT-1:0];
            end
            r_d4 <= r_d3;
            // Stage 5: recombine the halves.
            for (int i = 0; i < 6; i++) begin
                r_pr[i] <= (PRW'(r_hh[i]) <<< (2 * SPLIT))
                         + ((PRW'(r_hl[i]) + PRW'(r_lh[i])) <<< SPLIT)
                         + PRW'($signed({1'b0, r_ll[i]}));
            end
            r_d5 <= r_d4;
            // Stage 6: signed areas.
            r_vc <= cpt_pkg::AREAW'(r_pr[0]) - cpt_pkg::AREAW'(r_pr[1]);
            r_vb <= cpt_pkg::AREAW'(r_pr[2]) - cpt_pkg::AREAW'(r_pr[3]);
            r_va <= cpt_pkg::AREAW'(r_pr[4]) - cpt_pkg::AREAW'(r_pr[5]);
            r_d6 <= r_d5;
            // Stage 7: classified task.
            r_task <= w_task;
        end
    end

    always_comb begin
        d43 = EW'(r_d6[3]) - EW'(r_d6[2]);
        d56 = EW'(r_d6[4]) - EW'(r_d6[5]);
        den = cpt_pkg::QW'(r_va) + cpt_pkg::QW'(r_vb) + cpt_pkg::QW'(r_vc);

        if (r_d6[0] <= 0 && r_d6[1] <= 0) begin
            w_rg = RG_VA;
        end else if (r_d6[2] >= 0 && d43 <= 0) begin
            w_rg = RG_VB;
        end else if (r_vc <= 0 && r_d6[0] >= 0 && r_d6[2] <= 0) begin
            w_rg = RG_EAB;
        end else if (r_d6[5] >= 0 && d56 <= 0) begin
            w_rg = RG_VC;
        end else if (r_vb <= 0 && r_d6[1] >= 0 && r_d6[5] <= 0) begin
            w_rg = RG_EAC;
        end else if (r_va <= 0 && d43 >= 0 && d56 >= 0) begin
            w_rg = RG_EBC;
        end else if (den <= 0) begin
            w_rg = RG_DEGEN;
        end else begin
            w_rg = RG_FACE;
        end

        // An unused lane keeps a zero numerator, which divides to zero.
        w_task       = '0;
        w_task.geo   = r_geo[NST-2];
        unique case (w_rg)
            RG_VA: begin
            end
            RG_VB: begin
                w_task.nb = cpt_pkg::QW'(1);
                w_task.db = cpt_pkg::QW'(1);
            end
            RG_EAB: begin
                w_task.nb = cpt_pkg::QW'(r_d6[0]);
                w_task.db = cpt_pkg::QW'(r_d6[0]) - cpt_pkg::QW'(r_d6[2]);
            end
            RG_VC: begin
                w_task.nc = cpt_pkg::QW'(1);
                w_task.dc = cpt_pkg::QW'(1);
            end
            RG_EAC: begin
                w_task.nc = cpt_pkg::QW'(r_d6[1]);
                w_task.dc = cpt_pkg::QW'(r_d6[1]) - cpt_pkg::QW'(r_d6[5]);
            end
            RG_EBC: begin
                w_task.nc  = cpt_pkg::QW'(d43);
                w_task.dc  = cpt_pkg::QW'(d43) + cpt_pkg::QW'(d56);
                w_task.ebc = 1'b1;
            end
            RG_DEGEN: begin
                w_task.degen = 1'b1;
            end
            RG_FACE: begin
                w_task.nb   = cpt_pkg::QW'(r_vb);
                w_task.db   = den;
                w_task.nc   = cpt_pkg::QW'(r_vc);
                w_task.dc   = den;
                w_task.face = 1'b1;
            end
        endcase
    end

endmodule

>>> src/cpt_fifo.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: task queue
// Short queue between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module cpt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  cpt_pkg::t_task i_task,
    input  logic           i_rd,
    output cpt_pkg::t_task o_task,
    output logic           o_full,
    output logic           o_empty
);

    cpt_pkg::t_task             r_mem [cpt_pkg::Q_DEPTH];
    logic [cpt_pkg::QAW-1:0]    r_wp, r_rp;
    logic [cpt_pkg::QAW:0]      r_cnt;

    assign o_full  = (r_cnt == (cpt_pkg::QAW+1)'(cpt_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_task  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/cpt_back.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: back end
// Two pipelined dividers, weight settlement and point interpolation.
// ----------------------------------------------------------------------------
module cpt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  cpt_pkg::t_task i_task,
    output logic           o_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output cpt_pkg::t_out  o_item
);

    localparam int NS = cpt_pkg::WB + 1;

    typedef struct packed {
        logic          ebc;
        logic          face;
        logic          degen;
        cpt_pkg::t_geo geo;
    } t_side;

    function automatic cpt_pkg::t_lane lane_init(
        input logic signed [cpt_pkg::QW-1:0] n,
        input logic signed [cpt_pkg::QW-1:0] d
    );
        cpt_pkg::t_lane l;
        l.zero = (n <= 0) || (d <= 0);
        l.sat  = !l.zero && (n >= d);
        l.rem  = {1'b0, n};
        l.dvs  = {1'b0, d};
        l.q    = '0;
        return l;
    endfunction

    // One restoring step: the remainder stays below the divisor.
    function automatic cpt_pkg::t_lane div_step(input cpt_pkg::t_lane x);
        cpt_pkg::t_lane      y;
        logic [cpt_pkg::RW-1:0] r2;
        y  = x;
        r2 = x.rem << 1;
        if (r2 >= x.dvs) begin
            y.rem = r2 - x.dvs;
            y.q   = {x.q[cpt_pkg::WB-2:0], 1'b1};
        end else begin
            y.rem = r2;
            y.q   = {x.q[cpt_pkg::WB-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [cpt_pkg::WW-1:0] lane_result(input cpt_pkg::t_lane l);
        logic [cpt_pkg::WW-1:0] r;
        if (l.zero) begin
            r = '0;
        end else if (l.sat) begin
            r = cpt_pkg::W_ONE;
        end else begin
            r = {1'b0, l.q};
        end
        return r;
    endfunction

    logic                       en;
    logic [NS-1:0]              r_bv;
    cpt_pkg::t_lane             r_lb [NS], r_lc [NS];
    t_side                      r_side [NS];
    logic                       r_wv, r_mv, r_ov;
    logic [cpt_pkg::WW-1:0]     w_qb, w_qc, w_ub, w_uc;
    logic [cpt_pkg::WW:0]       w_sum;
    logic [cpt_pkg::WW-1:0]     r_ua, r_ub, r_uc, r_ua2, r_ub2, r_uc2;
    logic                       r_dg, r_dg2;
    cpt_pkg::t_geo              r_geo;
    logic [2:0][cpt_pkg::CW-1:0] r_a2;
    logic signed [cpt_pkg::PW-1:0] r_pb [3], r_pc [3];
    logic signed [cpt_pkg::TW-1:0] w_t [3];
    logic signed [cpt_pkg::CW-1:0] w_near [3];
    cpt_pkg::t_out              r_out;

    assign en      = !r_ov || i_pop;
    assign o_rd    = en && !i_q_empty;
    assign o_empty = !r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_wv <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[NS-2:0], !i_q_empty};
            r_wv <= r_bv[NS-1];
            r_mv <= r_wv;
            r_ov <= r_mv;
        end
    end

    always_comb begin
        w_qb  = lane_result(r_lb[NS-1]);
        w_qc  = lane_result(r_lc[NS-1]);
        w_ub  = r_side[NS-1].ebc ? (cpt_pkg::W_ONE - w_qc) : w_qb;
        w_sum = {1'b0, w_ub} + {1'b0, w_qc};
        if (r_side[NS-1].face && w_sum > {1'b0, cpt_pkg::W_ONE}) begin
            w_uc = cpt_pkg::W_ONE - w_ub;
        end else begin
            w_uc = w_qc;
        end
        for (int k = 0; k < 3; k++) begin
            w_t[k] = cpt_pkg::TW'(r_pb[k]) + cpt_pkg::TW'(r_pc[k])
                   + cpt_pkg::TW'(1 << (cpt_pkg::WB - 1));
            w_near[k] = $signed(r_a2[k]) + cpt_pkg::CW'(w_t[k] >>> cpt_pkg::WB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lb[0]   <= lane_init(i_task.nb, i_task.db);
            r_lc[0]   <= lane_init(i_task.nc, i_task.dc);
            r_side[0] <= '{ebc: i_task.ebc, face: i_task.face, degen: i_task.degen,
                           geo: i_task.geo};
            for (int s = 1; s < NS; s++) begin
                r_lb[s]   <= div_step(r_lb[s-1]);
                r_lc[s]   <= div_step(r_lc[s-1]);
                r_side[s] <= r_side[s-1];
            end
            // Weight settlement.
            r_ub  <= w_ub;
            r_uc  <= w_uc;
            r_ua  <= cpt_pkg::W_ONE - w_ub - w_uc;
            r_dg  <= r_side[NS-1].degen;
            r_geo <= r_side[NS-1].geo;
            // Weighted edges.
            for (int k = 0; k < 3; k++) begin
                r_pb[k] <= $signed({1'b0, r_ub}) * $signed(r_geo.ab[k]);
                r_pc[k] <= $signed({1'b0, r_uc}) * $signed(r_geo.ac[k]);
            end
            r_a2  <= r_geo.a;
            r_ua2 <= r_ua;
            r_ub2 <= r_ub;
            r_uc2 <= r_uc;
            r_dg2 <= r_dg;
            // Result register.
            r_out.near_x     <= w_near[0];
            r_out.near_y     <= w_near[1];
            r_out.near_z     <= w_near[2];
            r_out.weight_a   <= r_ua2;
            r_out.weight_b   <= r_ub2;
            r_out.weight_c   <= r_uc2;
            r_out.degenerate <= r_dg2;
        end
    end

endmodule

>>> src/closest_point_on_triangle_top.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: top level
// Classifies a query point against a triangle's Voronoi regions and returns
// the closest point with its barycentric weights.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Payload          Beat carries
//  --------  ----------------  ---------------  ------------------------------
//  input     push / full       i_item (t_in)    query point and three vertices
//  result    pop / empty       o_item (t_out)   closest point, weights, flag
//
//  A new beat is taken in every cycle while full is low; the block is fully
//  pipelined. After the edge that takes the input beat, a beat passes six
//  further front stages, the task queue and twenty back stages, of which
//  sixteen are the bit-per-stage divider steps.
//  Reset is synchronous and active low and empties every stage and the queue.
//  With pop low and a result waiting, the back end freezes; the front keeps
//  filling the four-entry queue and only raises full once that is occupied.
//
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  cpt_pkg::t_in   i_item,
    output logic           empty,
    input  logic           pop,
    output cpt_pkg::t_out  o_item
);

    logic           q_full, q_empty, q_wr, q_rd;
    cpt_pkg::t_task f_task, q_task;

    // Input is stalled only by the queue: the front pipeline holds whenever
    // the queue is full.
    assign full = q_full;

    // The front end computes the dot products and areas and decides the
    // region; each beat leaves it as one task holding a pair of divisions.
    cpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_q_full(q_full),
        .o_wr    (q_wr),
        .o_task  (f_task)
    );

    cpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_task  (f_task),
        .i_rd    (q_rd),
        .o_task  (q_task),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end runs both divisions, settles the weights and forms the
    // point; its last stage is the result register seen on the ports.
    cpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_task   (q_task),
        .o_rd     (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_item)
    );

`ifndef NO_ASSERTIONS
    // The three weights always make exactly one.
    a_weight_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ({1'b0, o_item.weight_a} + {1'b0, o_item.weight_b}
                    + {1'b0, o_item.weight_c}) == {1'b0, cpt_pkg::W_ONE})
        else $error("weights do not sum to one");

    // A degenerate triangle returns vertex a alone.
    a_degen_vertex : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.degenerate) |-> (o_item.weight_a == cpt_pkg::W_ONE))
        else $error("degenerate result not at vertex a");

    // Reset leaves no result pending and room for input.
    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("state survived reset");
`endif

endmodule

>>> dv/closest_point_on_triangle_checker.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: result checker
// Watches both channels, predicts every result from the accepted input beat
// and compares the result beats field by field, in order.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  cpt_pkg::t_in  i_in_item,
    input  logic          i_empty,
    input  logic          i_pop,
    input  cpt_pkg::t_out i_out_item,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_degenerates
);

    typedef logic signed [255:0] t_big;

    cpt_pkg::t_out nearest_q[$];

    // Weight quotient floor(n * 2^16 / d), clamped to [0, one].
    function automatic logic [cpt_pkg::WW-1:0] weight_ratio(t_big n, t_big d);
        if (n <= 0 || d <= 0) return '0;
        if (n >= d) return cpt_pkg::W_ONE;
        return cpt_pkg::WW'((n <<< cpt_pkg::WB) / d);
    endfunction

    function automatic cpt_pkg::t_out nearest_point(cpt_pkg::t_in it);
        t_big    p [3];
        t_big    a [3];
        t_big    b [3];
        t_big    c [3];
        t_big    ab[3];
        t_big    ac[3];
        t_big    ap[3];
        t_big    bp[3];
        t_big    cp[3];
        t_big    d1, d2, d3, d4, d5, d6, va, vb, vc, den, num, acc;
        t_big    wb_big, wc_big;
        logic [cpt_pkg::WW-1:0] ub, uc;
        logic    degen;
        cpt_pkg::t_out r;
        p[0] = $signed(it.point_x);  p[1] = $signed(it.point_y);  p[2] = $signed(it.point_z);
        a[0] = $signed(it.vert_a_x); a[1] = $signed(it.vert_a_y); a[2] = $signed(it.vert_a_z);
        b[0] = $signed(it.vert_b_x); b[1] = $signed(it.vert_b_y); b[2] = $signed(it.vert_b_z);
        c[0] = $signed(it.vert_c_x); c[1] = $signed(it.vert_c_y); c[2] = $signed(it.vert_c_z);
        for (int k = 0; k < 3; k++) begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        d1 = ab[0]*ap[0] + ab[1]*ap[1] + ab[2]*ap[2];
        d2 = ac[0]*ap[0] + ac[1]*ap[1] + ac[2]*ap[2];
        d3 = ab[0]*bp[0] + ab[1]*bp[1] + ab[2]*bp[2];
        d4 = ac[0]*bp[0] + ac[1]*bp[1] + ac[2]*bp[2];
        d5 = ab[0]*cp[0] + ab[1]*cp[1] + ab[2]*cp[2];
        d6 = ac[0]*cp[0] + ac[1]*cp[1] + ac[2]*cp[2];
        vc = d1*d4 - d3*d2;
        vb = d5*d2 - d1*d6;
        va = d3*d6 - d5*d4;
        ub = '0;
        uc = '0;
        degen = 1'b0;
        if (d1 <= 0 && d2 <= 0) begin
            // Nearest to vertex a: both weights stay zero.
        end else if (d3 >= 0 && d4 - d3 <= 0) begin
            ub = cpt_pkg::W_ONE;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            ub = weight_ratio(d1, d1 - d3);
        end else if (d6 >= 0 && d5 - d6 <= 0) begin
            uc = cpt_pkg::W_ONE;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            uc = weight_ratio(d2, d2 - d6);
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
            num = d4 - d3;
            uc  = weight_ratio(num, num + (d5 - d6));
            ub  = cpt_pkg::W_ONE - uc;
        end else begin
            den = va + vb + vc;
            if (den <= 0) begin
                degen = 1'b1;
            end else begin
                if (vb < 0) vb = 0;
                if (vc < 0) vc = 0;
                ub = weight_ratio(vb, den);
                uc = weight_ratio(vc, den);
                if ({1'b0, ub} + {1'b0, uc} > {1'b0, cpt_pkg::W_ONE}) begin
                    uc = cpt_pkg::W_ONE - ub;
                end
            end
        end
        wb_big = $signed({1'b0, ub});
        wc_big = $signed({1'b0, uc});
        for (int k = 0; k < 3; k++) begin
            acc = wb_big*ab[k] + wc_big*ac[k] + (t_big'(1) <<< (cpt_pkg::WB - 1));
            acc = a[k] + (acc >>> cpt_pkg::WB);
            case (k)
                0: r.near_x = acc[cpt_pkg::CW-1:0];
                1: r.near_y = acc[cpt_pkg::CW-1:0];
                default: r.near_z = acc[cpt_pkg::CW-1:0];
            endcase
        end
        r.weight_a   = cpt_pkg::W_ONE - ub - uc;
        r.weight_b   = ub;
        r.weight_c   = uc;
        r.degenerate = degen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cpt_pkg::t_out want;
        if (!i_rst_n) begin
            o_errors      <= 0;
            o_results     <= 0;
            o_degenerates <= 0;
            o_pending     <= 0;
            nearest_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                o_results <= o_results + 1;
                if (nearest_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %p", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = nearest_q.pop_front();
                    if (want.degenerate) o_degenerates <= o_degenerates + 1;
                    if (want !== i_out_item) begin
                        $display("%0t: result differs, expected %p, actual %p",
                                 $time, want, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_push && !i_full) nearest_q = {nearest_q, nearest_point(i_in_item)};
            o_pending <= nearest_q.size();
        end
    end

endmodule

>>> dv/closest_point_on_triangle_top_test.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: testbench top
// Drives directed and random point-triangle beats through four idling phases,
// with one long result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top_test;

    localparam int N_RANDOM   = 1200;
    localparam int IDLE_LIMIT = 3000;   // far above the hold-off length plus the pipeline latency
    localparam int HOLD_LEN   = 150;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  push = 1'b0;
    logic  pop = 1'b0;
    logic  full, empty;
    cpt_pkg::t_in   i_item = '0;
    cpt_pkg::t_out  o_item;

    int    errors, pending, results, degenerates;
    int    send_idle = 0;     // percentage of cycles the sender stays idle
    int    recv_stall = 0;    // percentage of cycles the receiver stalls
    int    hold_cycles = 0;   // requested long hold-off of the result side
    int    quiet = 0;
    int    sent = 0;

    always #6 i_clk = ~i_clk;

    closest_point_on_triangle_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    closest_point_on_triangle_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_in_item     (i_item),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_out_item    (o_item),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results),
        .o_degenerates (degenerates)
    );

    // The result side runs on its own. A hold-off request keeps pop low for a
    // counted stretch so that the queue fills and full is seen by the sender.
    initial begin
        int held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0 && held == 0) held = hold_cycles;
            if (held > 0) begin
                pop <= 1'b0;
                held--;
                if (held == 0) hold_cycles = 0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("closest_point_on_triangle_top: mismatch");
            $finish;
        end
    end

    // Offer one beat, idling first at the phase's rate, and return on the
    // falling edge after the beat has been taken.
    task automatic offer(cpt_pkg::t_in x);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= x;
        do @(posedge i_clk); while (full);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic cpt_pkg::t_in make_item(logic signed [cpt_pkg::CW-1:0] px, py, pz,
                                               logic signed [cpt_pkg::CW-1:0] ax, ay, az,
                                               logic signed [cpt_pkg::CW-1:0] bx, by, bz,
                                               logic signed [cpt_pkg::CW-1:0] cx, cy, cz);
        cpt_pkg::t_in x;
        x.point_x  = px; x.point_y  = py; x.point_z  = pz;
        x.vert_a_x = ax; x.vert_a_y = ay; x.vert_a_z = az;
        x.vert_b_x = bx; x.vert_b_y = by; x.vert_b_z = bz;
        x.vert_c_x = cx; x.vert_c_y = cy; x.vert_c_z = cz;
        return x;
    endfunction

    // A coordinate at one of three scales: full range, moderate or tiny.
    function automatic logic signed [cpt_pkg::CW-1:0] coord(int scale);
        case (scale)
            0:       return $urandom;
            1:       return $signed($urandom_range(1 << 20)) - (1 << 19);
            default: return $signed($urandom_range(32)) - 16;
        endcase
    endfunction

    // Random triangle and point. Most beats are sound triangles with the point
    // scattered around them, which visits every region; some are collinear or
    // have coincident vertices, to hit the zero-length edge and flat face paths.
    function automatic cpt_pkg::t_in random_item();
        cpt_pkg::t_in x;
        int scale, shape;
        logic signed [cpt_pkg::CW-1:0] k;
        scale = $urandom_range(9) < 2 ? 0 : ($urandom_range(9) < 7 ? 1 : 2);
        x = make_item(coord(scale), coord(scale), coord(scale),
                      coord(scale), coord(scale), coord(scale),
                      coord(scale), coord(scale), coord(scale),
                      coord(scale), coord(scale), coord(scale));
        shape = $urandom_range(19);
        if (shape == 0) begin
            x.vert_b_x = x.vert_a_x; x.vert_b_y = x.vert_a_y; x.vert_b_z = x.vert_a_z;
        end else if (shape == 1) begin
            x.vert_c_x = x.vert_a_x; x.vert_c_y = x.vert_a_y; x.vert_c_z = x.vert_a_z;
        end else if (shape == 2) begin
            x.vert_c_x = x.vert_b_x; x.vert_c_y = x.vert_b_y; x.vert_c_z = x.vert_b_z;
        end else if (shape == 3 && scale != 0) begin
            // c on the line through a and b
            k = $signed($urandom_range(6)) - 3;
            x.vert_c_x = x.vert_a_x + k * (x.vert_b_x - x.vert_a_x);
            x.vert_c_y = x.vert_a_y + k * (x.vert_b_y - x.vert_a_y);
            x.vert_c_z = x.vert_a_z + k * (x.vert_b_z - x.vert_a_z);
        end
        return x;
    endfunction

    task automatic run_phase(int idle, int stall, int count, bit squeeze);
        send_idle  = idle;
        recv_stall = stall;
        if (squeeze) hold_cycles = HOLD_LEN;
        for (int i = 0; i < count; i++) offer(random_item());
    endtask

    localparam logic signed [cpt_pkg::CW-1:0] MAXC = 32'sh7fffffff;
    localparam logic signed [cpt_pkg::CW-1:0] MINC = 32'sh80000000;
    localparam logic signed [cpt_pkg::CW-1:0] ONE  = 32'sh00010000;

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats on a unit right triangle a=(0,0,0) b=(1,0,0) c=(0,1,0).
        offer(make_item(-ONE, -ONE, 0,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));   // vertex a
        offer(make_item(2*ONE, -ONE, 0,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));  // vertex b
        offer(make_item(-ONE, 2*ONE, 5,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));  // vertex c
        offer(make_item(ONE/3, -ONE, 0,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));  // edge ab
        offer(make_item(-ONE, ONE/3, 0,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));  // edge ac
        offer(make_item(ONE, ONE, 0,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));     // edge bc
        offer(make_item(ONE/4, ONE/5, ONE,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0)); // face
        offer(make_item(ONE, 0, ONE,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0));     // above b, nearest to b
        // Zero-length edges and flat triangles.
        offer(make_item(ONE, ONE, ONE,  5, 5, 5,  5, 5, 5,  ONE, 0, 0));
        offer(make_item(ONE, ONE, ONE,  5, 5, 5,  0, ONE, 0,  5, 5, 5));
        offer(make_item(3, 7, -2,  9, 9, 9,  9, 9, 9,  9, 9, 9));
        offer(make_item(ONE, ONE, 0,  0, 0, 0,  ONE, ONE, ONE,  2*ONE, 2*ONE, 2*ONE));
        offer(make_item(0, 0, 0,  0, 0, 0,  0, 0, 0,  0, 0, 0));
        // Field extremes.
        offer(make_item(MAXC, MAXC, MAXC,  MINC, MINC, MINC,  MAXC, MINC, MAXC,
                        MINC, MAXC, MINC));
        offer(make_item(MINC, MINC, MINC,  MAXC, MAXC, MAXC,  MINC, MAXC, MINC,
                        MAXC, MINC, MAXC));
        offer(make_item(0, 0, 0,  MAXC, 0, 0,  0, MAXC, 0,  0, 0, MAXC));
        offer(make_item(MAXC, MAXC, MAXC,  MINC, 0, 0,  0, MINC, 0,  0, 0, MINC));
        offer(make_item(-1, -1, -1,  MINC, MINC, MINC,  MAXC, MAXC, MAXC,
                        MINC, MAXC, 0));
        offer(make_item(MAXC, MINC, 0,  -1, -1, -1,  MINC, MINC, MINC,
                        MAXC, MAXC, MAXC));

        // Random phases: free running, sender idling, receiver stalling with
        // one long hold-off, then both sides idling.
        run_phase(0,  0,  N_RANDOM / 4, 1'b0);
        run_phase(56, 0,  N_RANDOM / 4, 1'b0);
        run_phase(0,  56, N_RANDOM / 4, 1'b1);
        run_phase(21, 21, N_RANDOM / 4, 1'b0);
        push <= 1'b0;
        recv_stall = 0;

        // Drain, then let the pipeline run a little longer in case of strays.
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("Sent %0d beats of point and triangle, checked %0d results (%0d flat faces).",
                 sent, results, degenerates);
        $display("Phases: no idling, sender idle, receiver stall with hold-off, both idle.");
        if (errors == 0 && pending == 0) begin
            $display("closest_point_on_triangle_top: match");
        end else begin
            $display("closest_point_on_triangle_top: mismatch");
        end
        $finish;
    end

endmodule
